// File: rtl/iee_pkg.sv
`default_nettype none

package iee_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH       = 32;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_MUL  = 2'd1,
		OP_DIV  = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic div_zero;
	} md_stat_t;

endpackage

`default_nettype wire

// File: rtl/infix_expression_evaluator_unit.sv
// channel  direction  handshake              payload
// char     in         char_valid/char_stall  char_code[7:0], last_char
// res      out        res_valid/res_stall    value[31:0] signed, status
//
// Digits and whitespace are accepted one per cycle unless last_char is set.
// A character that closes a pending * or / stalls the input while the shared shift-add /
// restoring-divide unit resolves one bit a cycle (a zero divisor skips the iterations).
// The last item passes through a finishing state, through the arithmetic unit again if a
// product is still pending, and then the result register is loaded.
// Reset clears all expression state; no clearing pass is needed.
// A waiting result stalls the input only when the next result is ready to load.
`default_nettype none

module infix_expression_evaluator_unit #(
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                char_valid,
	output logic                                     char_stall,
	input  wire logic [7:0]                          char_code,
	input  wire logic                                last_char,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output logic signed [iee_pkg::OUT_WIDTH-1:0]     value,
	output logic                                     status
);
	import iee_pkg::*;

	localparam int W = VALUE_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_APPLY  = 5'b00010,
		ST_FIN    = 5'b00100,
		ST_FAPPLY = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  cur_q;
	logic [W-1:0]  prod_q;
	op_t           op_q;
	logic [W-1:0]  sum_q;
	logic          neg_q;
	logic          dz_q;
	logic          last_q;
	logic [7:0]    char_q;
	logic          res_valid_q;

	md_req_t       md_req;
	md_stat_t      md_st;
	logic [W-1:0]  md_result;

	logic          char_acc;
	logic          is_ws;
	logic          is_digit;
	logic [W-1:0]  cur_next;
	logic [7:0]    close_char;
	logic [W-1:0]  term_val;
	logic [W-1:0]  term_sum;
	logic          emit_go;

	assign char_stall = (state_q != ST_IDLE);
	assign char_acc   = char_valid && !char_stall;

	assign is_ws    = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign cur_next = {cur_q[W-4:0], 3'b000} + {cur_q[W-2:0], 1'b0}
		+ W'(char_code - CH_ZERO);

	assign close_char = (state_q == ST_IDLE) ? char_code : char_q;
	assign term_val   = (state_q == ST_APPLY || state_q == ST_FAPPLY) ? md_result : cur_q;
	assign term_sum   = neg_q ? (sum_q - term_val) : (sum_q + term_val);

	assign emit_go = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		md_req.op    = op_q;
		md_req.start = 1'b0;
		if (op_q != OP_NONE) begin
			if (state_q == ST_FIN) begin
				md_req.start = 1'b1;
			end else if (char_acc && !is_ws && !is_digit) begin
				md_req.start = 1'b1;
			end
		end
	end

	iee_muldiv #(
		.W(W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (prod_q),
		.b      (cur_q),
		.stat   (md_st),
		.result (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			prod_q  <= '0;
			op_q    <= OP_NONE;
			sum_q   <= '0;
			neg_q   <= 1'b0;
			dz_q    <= 1'b0;
			last_q  <= 1'b0;
			char_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (char_acc) begin
						last_q <= last_char;
						char_q <= char_code;
						if (is_ws) begin
							state_q <= last_char ? ST_FIN : ST_IDLE;
						end else if (is_digit) begin
							cur_q   <= cur_next;
							state_q <= last_char ? ST_FIN : ST_IDLE;
						end else if (op_q == OP_NONE) begin
							cur_q <= '0;
							if (close_char == CH_STAR || close_char == CH_SLASH) begin
								op_q   <= (close_char == CH_STAR) ? OP_MUL : OP_DIV;
								prod_q <= term_val;
							end else begin
								sum_q <= term_sum;
								neg_q <= (close_char != CH_PLUS);
							end
							state_q <= last_char ? ST_FIN : ST_IDLE;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					if (md_st.done) begin
						dz_q  <= dz_q | md_st.div_zero;
						cur_q <= '0;
						if (close_char == CH_STAR || close_char == CH_SLASH) begin
							op_q   <= (close_char == CH_STAR) ? OP_MUL : OP_DIV;
							prod_q <= term_val;
						end else begin
							op_q  <= OP_NONE;
							sum_q <= term_sum;
							neg_q <= (close_char != CH_PLUS);
						end
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (op_q == OP_NONE) begin
						sum_q   <= term_sum;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_FAPPLY;
					end
				end
				ST_FAPPLY: begin
					if (md_st.done) begin
						dz_q    <= dz_q | md_st.div_zero;
						sum_q   <= term_sum;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						// result handed off, start the next expression clean
						cur_q   <= '0;
						prod_q  <= '0;
						op_q    <= OP_NONE;
						sum_q   <= '0;
						neg_q   <= 1'b0;
						dz_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			value  <= OUT_WIDTH'(signed'(sum_q));
			status <= dz_q;
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_md_done_in_apply: assert property (@(posedge clk) disable iff (!arst_n)
		md_st.done |-> (state_q == ST_APPLY || state_q == ST_FAPPLY))
		else $error("arithmetic unit finished outside an apply state");

	a_md_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_st.busy)
		else $error("arithmetic unit started while busy");

	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised without a finished expression");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (op_q == OP_NONE && sum_q == '0 && !dz_q && cur_q == '0))
		else $error("expression state not cleared after result");
`endif

endmodule

`default_nettype wire

// File: rtl/iee_muldiv.sv
`default_nettype none

module iee_muldiv #(
	parameter int W = iee_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire iee_pkg::md_req_t req,
	input  wire logic [W-1:0]     a,
	input  wire logic [W-1:0]     b,
	output iee_pkg::md_stat_t     stat,
	output logic      [W-1:0]     result
);
	import iee_pkg::*;

	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_RUN  = 3'b010,
		MD_DONE = 3'b100
	} md_state_t;

	md_state_t     st_q;
	logic          is_div_q;
	logic          neg_q;
	logic          dz_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W:0]    r_q;

	logic          a_neg;
	logic          b_neg;
	logic [W-1:0]  a_mag;
	logic [W-1:0]  b_mag;
	logic [W:0]    rem_sh;
	logic [W:0]    diff;
	logic [W-1:0]  acc_next;

	assign a_neg = a[W-1];
	assign b_neg = b[W-1];
	assign a_mag = a_neg ? (~a + W'(1)) : a;
	assign b_mag = b_neg ? (~b + W'(1)) : b;

	assign rem_sh   = {r_q[W-1:0], x_q[W-1]};
	assign diff     = rem_sh - {1'b0, y_q};
	assign acc_next = r_q[W-1:0] + (y_q[0] ? x_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= MD_IDLE;
			is_div_q <= 1'b0;
			neg_q    <= 1'b0;
			dz_q     <= 1'b0;
			cnt_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			r_q      <= '0;
		end else begin
			unique case (st_q)
				MD_IDLE: begin
					if (req.start) begin
						r_q   <= '0;
						cnt_q <= CW'(W - 1);
						dz_q  <= 1'b0;
						if (req.op == OP_DIV) begin
							is_div_q <= 1'b1;
							if (b == '0) begin
								// quotient of zero, flag it and skip the iterations
								x_q   <= '0;
								neg_q <= 1'b0;
								dz_q  <= 1'b1;
								st_q  <= MD_DONE;
							end else begin
								x_q   <= a_mag;
								y_q   <= b_mag;
								neg_q <= a_neg ^ b_neg;
								st_q  <= MD_RUN;
							end
						end else begin
							is_div_q <= 1'b0;
							neg_q    <= 1'b0;
							x_q      <= a;
							y_q      <= b;
							st_q     <= MD_RUN;
						end
					end
				end
				MD_RUN: begin
					if (is_div_q) begin
						// one quotient bit per cycle, shifted in behind the dividend
						if (!diff[W]) begin
							r_q <= diff;
						end else begin
							r_q <= rem_sh;
						end
						x_q <= {x_q[W-2:0], ~diff[W]};
					end else begin
						r_q <= {1'b0, acc_next};
						x_q <= {x_q[W-2:0], 1'b0};
						y_q <= {1'b0, y_q[W-1:1]};
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						st_q <= MD_DONE;
					end
				end
				MD_DONE: begin
					st_q <= MD_IDLE;
				end
				default: begin
					st_q <= MD_IDLE;
				end
			endcase
		end
	end

	assign result        = is_div_q ? (neg_q ? (~x_q + W'(1)) : x_q) : r_q[W-1:0];
	assign stat.busy     = (st_q != MD_IDLE);
	assign stat.done     = (st_q == MD_DONE);
	assign stat.div_zero = dz_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import iee_pkg::*;

	localparam byte unsigned CH_MINUS = 8'h2D;
	localparam int DRAIN_CYCLES = 2 * VALUE_WIDTH_DEF + 16;

	typedef struct {
		logic [31:0] value;
		logic        status;
	} eval_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	logic [7:0]  char_code;
	logic        last_char;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic signed [OUT_WIDTH-1:0] value;
	logic        status;

	int src_idle_pct;
	int sink_stall_pct;
	int mismatch_count = 0;

	// expression state of the predictor
	logic [31:0] expr_number;
	logic [31:0] expr_operand;
	op_t         expr_op;
	logic [31:0] expr_sum;
	logic        expr_negative;
	logic        expr_div_zero;

	eval_result_t expected_results[$];
	eval_result_t want;

	infix_expression_evaluator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code (char_code),
		.last_char (last_char),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_expression();
		expr_number   = '0;
		expr_operand  = '0;
		expr_op       = OP_NONE;
		expr_sum      = '0;
		expr_negative = 1'b0;
		expr_div_zero = 1'b0;
	endfunction

	// signed division, truncating toward zero; most negative / -1 wraps
	function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		if (b == '0) begin
			expr_div_zero = 1'b1;
			return '0;
		end
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] resolve_product();
		case (expr_op)
			OP_MUL: return expr_operand * expr_number;
			OP_DIV: return signed_quotient(expr_operand, expr_number);
			default: return expr_number;
		endcase
	endfunction

	function automatic void close_term();
		expr_sum = expr_sum + (expr_negative ? -expr_number : expr_number);
	endfunction

	function automatic void append_byte(ref byte unsigned q[$], input byte unsigned b);
		q.insert(q.size(), b);
	endfunction

	function automatic void advance_expression(byte unsigned code, bit last);
		eval_result_t r;
		if ((code >= CH_TAB && code <= CH_CR) || code == CH_SPACE) begin
			// skip whitespace
		end else if (code >= CH_ZERO && code <= CH_NINE) begin
			expr_number = expr_number * 32'd10 + 32'(code - CH_ZERO);
		end else begin
			expr_number = resolve_product();
			expr_op = OP_NONE;
			if (code == CH_STAR || code == CH_SLASH) begin
				expr_op = (code == CH_STAR) ? OP_MUL : OP_DIV;
				expr_operand = expr_number;
			end else begin
				close_term();
				expr_negative = (code != CH_PLUS);
			end
			expr_number = '0;
		end
		if (last) begin
			expr_number = resolve_product();
			expr_op = OP_NONE;
			close_term();
			r.value = expr_sum;
			r.status = expr_div_zero;
			expected_results.insert(expected_results.size(), r);
			clear_expression();
		end
	endfunction

	task automatic send_char(input byte unsigned code, input bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= code;
		last_char <= last;
		advance_expression(code, last);
		do @(posedge clk); while (char_stall);
	endtask

	task automatic send_expression(input byte unsigned chars[$]);
		foreach (chars[i])
			send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		byte unsigned chars[$];
		for (int i = 0; i < s.len(); i++)
			append_byte(chars, s[i]);
		send_expression(chars);
	endtask

	function automatic void add_blanks(ref byte unsigned q[$]);
		if ($urandom_range(3) == 0)
			append_byte(q, $urandom_range(1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
	endfunction

	function automatic byte unsigned pick_operator();
		case ($urandom_range(9))
			0, 1: return CH_PLUS;
			2, 3: return CH_MINUS;
			4, 5: return CH_STAR;
			6, 7, 8: return CH_SLASH;
			default: return 8'($urandom_range(8'h3A, 8'h7E));
		endcase
	endfunction

	task automatic test_precedence();
		send_text("1+2*3-8/3 ");
	endtask

	task automatic test_division_extremes();
		send_text("2147483648/4294967295");
		send_text("9/0");
	endtask

	task automatic test_odd_characters();
		byte unsigned chars[$];
		send_text("x*");
		chars = {8'hFF, 8'h00};
		send_expression(chars);
	endtask

	task automatic test_random_expressions(input int char_budget);
		byte unsigned chars[$];
		string extreme;
		int sent;
		int kind;
		int r;
		sent = 0;
		while (sent < char_budget) begin
			chars = {};
			kind = $urandom_range(99);
			if (kind < 12) begin
				// raw bytes, mostly junk
				repeat ($urandom_range(1, 6))
					append_byte(chars, 8'($urandom_range(255)));
			end else begin
				for (int t = 0; t < $urandom_range(1, 6); t++) begin
					if (t > 0 || $urandom_range(3) == 0)
						append_byte(chars, pick_operator());
					add_blanks(chars);
					r = $urandom_range(99);
					if (r < 8) begin
						append_byte(chars, CH_ZERO);
					end else if (r < 20) begin
						extreme = (r < 14) ? "4294967295" : "2147483648";
						for (int i = 0; i < extreme.len(); i++)
							append_byte(chars, extreme[i]);
					end else begin
						repeat (r < 26 ? $urandom_range(4, 12) : $urandom_range(1, 3))
							append_byte(chars, 8'(CH_ZERO + $urandom_range(9)));
					end
					add_blanks(chars);
				end
				// end on a dangling operator now and then
				if (kind < 20)
					append_byte(chars, pick_operator());
			end
			send_expression(chars);
			sent += chars.size();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: value=%0d status=%0b", value, status);
			end else begin
				want = expected_results.pop_front();
				if (value !== want.value || status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected value=%0d status=%0b, got value=%0d status=%0b",
							$signed(want.value), want.status, value, status);
				end
			end
		end
		res_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		src_idle_pct = 21;
		sink_stall_pct = 48;
		clear_expression();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_precedence();
		test_division_extremes();
		test_odd_characters();
		test_random_expressions(400);

		src_idle_pct = 48;
		sink_stall_pct = 21;
		test_random_expressions(400);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_expressions(400);

		char_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/iee_pkg.sv
rtl/iee_muldiv.sv
rtl/infix_expression_evaluator_unit.sv
dv/testbench.sv
